@@ rtl/vpsw_pkg.sv @@
// Shared types and constants for the Verlet particle step with walls.
// No dependencies; every other file imports this package.
`default_nettype none

package vpsw_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int GRID_CELLS = 64;
  localparam int CELL_DIV   = 15;

  localparam int POS_W  = 24;
  localparam int RAD_W  = 16;
  localparam int WALL_W = 23;
  localparam int CELL_W = 6;

  // velocity and clamped position need one bit more than a position
  localparam int VEL_W = POS_W + 1;
  // position + reflected velocity + acceleration step
  localparam int SUM_W = POS_W + 4;

  // grid cell: whole units divided by CELL_DIV via reciprocal multiply
  localparam int CELL_SPAN   = CELL_DIV << FRAC_BITS;
  localparam int CELL_LIMIT  = GRID_CELLS * CELL_SPAN;
  localparam int CELL_IDX_W  = $clog2(GRID_CELLS * CELL_DIV);
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = (1 << RECIP_SHIFT) / CELL_DIV + 1;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = CELL_IDX_W + RECIP_W;

  // APB register file
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [WALL_W-1:0] WALL_RESET = WALL_W'(204800);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WALL_LIMIT = 2'd0,
    REG_ACCEL_X    = 2'd1,
    REG_ACCEL_Y    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        [WALL_W-1:0] wall_limit;
    logic signed [POS_W-1:0]  accel_step_x;
    logic signed [POS_W-1:0]  accel_step_y;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic signed [POS_W-1:0] prev_x;
    logic signed [POS_W-1:0] prev_y;
    logic        [RAD_W-1:0] particle_radius;
  } particle_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  next_x;
    logic signed [POS_W-1:0]  next_y;
    logic signed [POS_W-1:0]  next_prev_x;
    logic signed [POS_W-1:0]  next_prev_y;
    logic        [CELL_W-1:0] cell_col;
    logic        [CELL_W-1:0] cell_row;
  } update_t;

endpackage

`default_nettype wire

@@ rtl/particle_if.sv @@
// Particle request channel: valid/ready handshake plus one particle.
// Depends on vpsw_pkg.
`default_nettype none

interface particle_if;
  import vpsw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] cur_x;
  logic signed [POS_W-1:0] cur_y;
  logic signed [POS_W-1:0] prev_x;
  logic signed [POS_W-1:0] prev_y;
  logic        [RAD_W-1:0] particle_radius;

  modport source (
    output valid, cur_x, cur_y, prev_x, prev_y, particle_radius,
    input  ready
  );

  modport sink (
    input  valid, cur_x, cur_y, prev_x, prev_y, particle_radius,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/update_if.sv @@
// Update request channel: valid/ready handshake plus one particle update.
// Depends on vpsw_pkg.
`default_nettype none

interface update_if;
  import vpsw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  next_x;
  logic signed [POS_W-1:0]  next_y;
  logic signed [POS_W-1:0]  next_prev_x;
  logic signed [POS_W-1:0]  next_prev_y;
  logic        [CELL_W-1:0] cell_col;
  logic        [CELL_W-1:0] cell_row;

  modport source (
    output valid, next_x, next_y, next_prev_x, next_prev_y, cell_col, cell_row,
    input  ready
  );

  modport sink (
    input  valid, next_x, next_y, next_prev_x, next_prev_y, cell_col, cell_row,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/vpsw_regs.sv @@
// APB configuration registers: wall limit and the two acceleration steps.
// Depends on vpsw_pkg.
`default_nettype none

module vpsw_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vpsw_pkg::ADDR_W-1:0] paddr,
  input  logic [vpsw_pkg::DATA_W-1:0] pwdata,
  output logic [vpsw_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output vpsw_pkg::cfg_t              cfg
);
  import vpsw_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_limit   <= WALL_RESET;
      cfg.accel_step_x <= '0;
      cfg.accel_step_y <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WALL_LIMIT: cfg.wall_limit   <= pwdata[WALL_W-1:0];
        REG_ACCEL_X:    cfg.accel_step_x <= signed'(pwdata[POS_W-1:0]);
        REG_ACCEL_Y:    cfg.accel_step_y <= signed'(pwdata[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WALL_LIMIT: prdata = DATA_W'(cfg.wall_limit);
      REG_ACCEL_X:    prdata = DATA_W'(cfg.accel_step_x);
      REG_ACCEL_Y:    prdata = DATA_W'(cfg.accel_step_y);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/vpsw_calc.sv @@
// Per-particle datapath: wall clamp and reflection, Verlet step, grid cell.
// Purely combinational; depends on vpsw_pkg.
`default_nettype none

module vpsw_calc (
  input  vpsw_pkg::cfg_t      cfg,
  input  vpsw_pkg::particle_t p,
  output vpsw_pkg::update_t   u
);
  import vpsw_pkg::*;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(POS_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi)      sat_pos = hi[POS_W-1:0];
    else if (v < lo) sat_pos = lo[POS_W-1:0];
    else             sat_pos = v[POS_W-1:0];
  endfunction

  // three quarters, rounded toward minus infinity
  function automatic logic signed [VEL_W-1:0] damp(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W+1:0] v3;
    v3   = ((VEL_W+2)'(v) <<< 1) + (VEL_W+2)'(v);
    damp = signed'(v3[VEL_W+1:2]);
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic signed [POS_W-1:0] pos);
    logic [CELL_IDX_W-1:0] n;
    logic [PROD_W-1:0]     prod;
    logic [CELL_W-1:0]     c;
    n    = pos[FRAC_BITS +: CELL_IDX_W];
    prod = PROD_W'(n) * PROD_W'(RECIP);
    if (pos[POS_W-1])
      c = '0;
    else if (32'(unsigned'(pos)) >= 32'(CELL_LIMIT))
      c = CELL_W'(GRID_CELLS - 1);
    else
      c = CELL_W'(prod >> RECIP_SHIFT);
    cell_of = c;
  endfunction

  logic signed [VEL_W-1:0] cx, cy, px, py, rad, wall;
  logic signed [VEL_W-1:0] vx, vy, xc, yc;
  logic signed [VEL_W:0]   dx, dy;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                    lo_x, hi_x, lo_y, hi_y, x_hit, y_hit;
  logic signed [POS_W-1:0] nx, ny;

  assign cx   = VEL_W'(signed'(p.cur_x));
  assign cy   = VEL_W'(signed'(p.cur_y));
  assign px   = VEL_W'(signed'(p.prev_x));
  assign py   = VEL_W'(signed'(p.prev_y));
  assign rad  = signed'(VEL_W'(p.particle_radius));
  assign wall = signed'(VEL_W'(cfg.wall_limit));

  assign vx = cx - px;
  assign vy = cy - py;

  assign lo_x  = cx < rad;
  assign hi_x  = cx + rad > wall;
  assign lo_y  = cy < rad;
  assign hi_y  = cy + rad > wall;
  assign x_hit = lo_x || hi_x;
  assign y_hit = lo_y || hi_y;

  // upper clamp wins when the window is narrower than the particle
  assign xc = hi_x ? wall - rad : (lo_x ? rad : cx);
  assign yc = hi_y ? wall - rad : (lo_y ? rad : cy);

  // effective velocity after the walls; a y hit overrides an x hit
  always_comb begin
    if (y_hit) begin
      dx = (VEL_W+1)'(damp(vx));
      dy = -(VEL_W+1)'(vy);
    end else if (x_hit) begin
      dx = -(VEL_W+1)'(vx);
      dy = (VEL_W+1)'(damp(vy));
    end else begin
      dx = (VEL_W+1)'(vx);
      dy = (VEL_W+1)'(vy);
    end
  end

  assign sum_x = SUM_W'(xc) + SUM_W'(dx) + SUM_W'(cfg.accel_step_x);
  assign sum_y = SUM_W'(yc) + SUM_W'(dy) + SUM_W'(cfg.accel_step_y);
  assign nx    = sat_pos(sum_x);
  assign ny    = sat_pos(sum_y);

  assign u.next_x      = nx;
  assign u.next_y      = ny;
  // clamped position lies in [-max radius, max wall], always a legal position
  assign u.next_prev_x = xc[POS_W-1:0];
  assign u.next_prev_y = yc[POS_W-1:0];
  assign u.cell_col    = cell_of(nx);
  assign u.cell_row    = cell_of(ny);

endmodule

`default_nettype wire

@@ rtl/verlet_particle_step_with_walls.sv @@
// Top level: particle input register, datapath, update output register, APB regs.
// Depends on vpsw_pkg, particle_if, update_if, vpsw_regs and vpsw_calc.
`default_nettype none

// One particle update per clock while the update side keeps up. An accepted
// particle request is captured in the input register; a single combinational
// pass through the wall and Verlet logic then computes its update, which is
// loaded into the result register that drives the update request. The input
// register moves on whenever the result register is empty or being taken. A
// new particle is therefore taken every cycle while the update side keeps up,
// and one more is held while an update waits. Configuration is written over
// APB at 0x0 (wall limit), 0x4 (x acceleration step) and 0x8 (y acceleration
// step); write it only when no particle is in flight.
module verlet_particle_step_with_walls (
  input  logic                        clk,
  input  logic                        rst,
  particle_if.sink                    particle,
  update_if.source                    update,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vpsw_pkg::ADDR_W-1:0] paddr,
  input  logic [vpsw_pkg::DATA_W-1:0] pwdata,
  output logic [vpsw_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import vpsw_pkg::*;

  cfg_t      cfg;
  particle_t s1;
  particle_t p_in;
  update_t   res;
  update_t   res_q;
  logic      s1_valid;
  logic      s1_adv;
  logic      out_valid;

  vpsw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign p_in.cur_x           = particle.cur_x;
  assign p_in.cur_y           = particle.cur_y;
  assign p_in.prev_x          = particle.prev_x;
  assign p_in.prev_y          = particle.prev_y;
  assign p_in.particle_radius = particle.particle_radius;

  assign s1_adv         = !out_valid || update.ready;
  assign particle.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (particle.ready) s1_valid <= particle.valid;
      if (s1_adv) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (particle.valid && particle.ready) s1 <= p_in;
    if (s1_adv && s1_valid) res_q <= res;
  end

  vpsw_calc u_calc (
    .cfg (cfg),
    .p   (s1),
    .u   (res)
  );

  assign update.valid       = out_valid;
  assign update.next_x      = res_q.next_x;
  assign update.next_y      = res_q.next_y;
  assign update.next_prev_x = res_q.next_prev_x;
  assign update.next_prev_y = res_q.next_prev_y;
  assign update.cell_col    = res_q.cell_col;
  assign update.cell_row    = res_q.cell_row;

  // a particle held behind a stalled update must not move or vanish
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1)))
    else $error("input stage lost or changed a held particle");

  a_s1_take: assert property (@(posedge clk) disable iff (rst)
    (particle.valid && particle.ready) |=> s1_valid)
    else $error("accepted particle did not reach the input stage");

  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("update valid without a particle behind it");

  // positions left of or below the origin land in cell zero
  a_cell_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!update.next_x[POS_W-1] || update.cell_col == '0) &&
                   (!update.next_y[POS_W-1] || update.cell_row == '0)))
    else $error("negative position mapped to a nonzero cell");

endmodule

`default_nettype wire
